@@ hw/rtl/rkdo_pkg.sv @@
// ----------------------------------------------------------------------------
// rkdo_pkg: shared types and constants of the dense output interpolator
// Coefficient table (signed Q.40), widths and the stage payload record.
// ----------------------------------------------------------------------------
package rkdo_pkg;

  localparam int unsigned NUM_LANES  = 5;
  localparam int unsigned NUM_STAGES = 15;

  localparam logic signed [63:0] Q40    = 64'sd1 <<< 40;
  localparam logic signed [63:0] SQ21   = 64'sd5038595261768;
  localparam logic [31:0]        TH_ONE = 32'h8000_0000;

  localparam logic [6:0] SH_THETA = 7'd31;
  localparam logic [6:0] SH_BASIS = 7'd40;
  localparam logic [6:0] SH_INC   = 7'd32;

  localparam logic signed [63:0] INC_LIM = 64'sd562949953421312;
  localparam logic signed [63:0] Y_MAX   = 64'sd140737488355327;
  localparam logic signed [63:0] Y_MIN   = -64'sd140737488355328;

  // Basis coefficients, index 0..3 for theta^1..theta^4, rounded half away
  // from zero.
  localparam logic signed [63:0] COEF [NUM_LANES][4] = '{
    '{ -(64'sd5 * Q40), 64'sd10 * Q40, -((64'sd35 * Q40 + 64'sd2) / 64'sd4),
       (64'sd14 * Q40 + 64'sd2) / 64'sd5 },
    '{ (64'sd49 * Q40 + 64'sd7 * SQ21 + 64'sd6) / 64'sd12,
       -((64'sd245 * Q40 + 64'sd21 * SQ21 + 64'sd9) / 64'sd18),
       (64'sd196 * Q40 + 64'sd7 * SQ21 + 64'sd6) / 64'sd12,
       -((64'sd98 * Q40 + 64'sd7) / 64'sd15) },
    '{ -((64'sd8 * Q40 + 64'sd1) / 64'sd3), (64'sd128 * Q40 + 64'sd4) / 64'sd9,
       -((64'sd56 * Q40 + 64'sd1) / 64'sd3), (64'sd112 * Q40 + 64'sd7) / 64'sd15 },
    '{ (64'sd49 * Q40 - 64'sd7 * SQ21 + 64'sd6) / 64'sd12,
       -((64'sd245 * Q40 - 64'sd21 * SQ21 + 64'sd9) / 64'sd18),
       (64'sd196 * Q40 - 64'sd7 * SQ21 + 64'sd6) / 64'sd12,
       -((64'sd98 * Q40 + 64'sd7) / 64'sd15) },
    '{ -((64'sd1 * Q40 + 64'sd1) / 64'sd2), 64'sd3 * Q40,
       -((64'sd21 * Q40 + 64'sd2) / 64'sd4), (64'sd14 * Q40 + 64'sd2) / 64'sd5 }
  };

  typedef struct packed {
    logic [31:0]                      theta;
    logic [NUM_LANES-1:0][47:0]       k;
    logic signed [47:0]               y;
    logic signed [63:0]               thh;
    logic                             last;
  } pipe_t;

endpackage

@@ hw/rtl/rkdo_cell.sv @@
// ----------------------------------------------------------------------------
// rkdo_cell: two-stage multiply, round and accumulate cell
// Stage one forms four 32x32 partial products; stage two sums them, rounds
// half away from zero, shifts, saturates and adds the addend.
// ----------------------------------------------------------------------------
module rkdo_cell (
  input  logic               clk,
  input  logic               en_a,
  input  logic               en_b,
  input  logic signed [63:0] op_a,
  input  logic signed [63:0] op_b,
  input  logic [6:0]         shamt,
  input  logic signed [63:0] addend,
  output logic signed [63:0] res
);
  import rkdo_pkg::*;

  logic [63:0]        mag_a, mag_b;
  logic [63:0]        pp00_r, pp01_r, pp10_r, pp11_r;
  logic               neg_r;
  logic signed [63:0] add_r;
  logic [127:0]       full, rnd, quo;
  logic [63:0]        mag;
  logic signed [63:0] sval, res_nxt, res_r;

  assign mag_a = op_a[63] ? (~op_a + 64'd1) : op_a;
  assign mag_b = op_b[63] ? (~op_b + 64'd1) : op_b;

  always_ff @(posedge clk) begin
    if (en_a) begin
      pp00_r <= 64'(mag_a[31:0])  * 64'(mag_b[31:0]);
      pp01_r <= 64'(mag_a[31:0])  * 64'(mag_b[63:32]);
      pp10_r <= 64'(mag_a[63:32]) * 64'(mag_b[31:0]);
      pp11_r <= 64'(mag_a[63:32]) * 64'(mag_b[63:32]);
      neg_r  <= op_a[63] ^ op_b[63];
      add_r  <= addend;
    end
  end

  always_comb begin
    rnd  = 128'd1 << (shamt - 7'd1);
    full = {64'd0, pp00_r} + {32'd0, pp01_r, 32'd0} + {32'd0, pp10_r, 32'd0}
         + {pp11_r, 64'd0} + rnd;
    quo  = full >> shamt;
    mag  = (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
    sval = neg_r ? -$signed(mag) : $signed(mag);
    res_nxt = add_r + sval;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ hw/rtl/rk_dense_output_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// rk_dense_output_interpolator_top: Runge-Kutta dense output interpolation
// Evaluates five quartic basis polynomials in theta by Horner's rule, weights
// the stages, scales by theta*h, adds y and saturates to 48 bits.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid/in_ready, theta, h, y, k1, k8,   | in
//          | k9..k11, is_last                          |
//  result  | out_valid/out_ready, y_interpolated, last | out
//
// One transfer per cycle in each direction while the result side is not stalled.
// The chain has 15 register stages (entry, four Horner cells, one stage-weight
// cell and one increment cell, plus sum and final saturation).
// Reset clears only the per-stage valid bits.
// A stage holds only when it is full and the stage after it holds, so bubbles
// squeeze out and input keeps flowing while a result waits, until the chain fills.
// ----------------------------------------------------------------------------
module rk_dense_output_interpolator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_frac_theta,
  input  logic [46:0]        in_step_size,
  input  logic signed [47:0] in_y_value,
  input  logic signed [47:0] in_stage_k1,
  input  logic signed [47:0] in_stage_k8,
  input  logic signed [47:0] in_stage_k9,
  input  logic signed [47:0] in_stage_k10,
  input  logic signed [47:0] in_stage_k11,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_y_interpolated,
  output logic               out_last_out
);
  import rkdo_pkg::*;

  logic [NUM_STAGES-1:0] v_r, v_nxt;
  logic [NUM_STAGES:0]   en;
  pipe_t                 pl_r [NUM_STAGES-1];
  pipe_t                 pl_nxt [NUM_STAGES-1];

  logic signed [63:0] h1 [NUM_LANES];
  logic signed [63:0] h2 [NUM_LANES];
  logic signed [63:0] h3 [NUM_LANES];
  logic signed [63:0] h4 [NUM_LANES];
  logic signed [63:0] term [NUM_LANES];
  logic signed [63:0] thh_res, inc_res;
  logic signed [63:0] sum_r, sum_nxt;
  logic signed [63:0] inc_c, r_full, r_sat;
  logic signed [47:0] y_r, y_nxt;
  logic               last_r;
  logic [46:0]        h_r;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[NUM_STAGES] = out_ready;
    for (int n = NUM_STAGES - 1; n >= 0; n--) begin
      en[n] = !v_r[n] || en[n+1];
    end
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int n = 1; n < NUM_STAGES; n++) begin
      if (en[n]) begin
        v_nxt[n] = v_r[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[0];

  // Entry stage: clamp theta to one and capture the payload.
  always_comb begin
    pl_nxt[0].theta = (in_frac_theta > TH_ONE) ? TH_ONE : in_frac_theta;
    pl_nxt[0].k     = {in_stage_k11, in_stage_k10, in_stage_k9, in_stage_k8,
                       in_stage_k1};
    pl_nxt[0].y     = in_y_value;
    pl_nxt[0].thh   = '0;
    pl_nxt[0].last  = in_is_last;
    for (int n = 1; n < NUM_STAGES - 1; n++) begin
      pl_nxt[n] = pl_r[n-1];
      if (n == 3) begin
        pl_nxt[n].thh = thh_res;
      end
    end
  end

  for (genvar n = 0; n < NUM_STAGES - 1; n++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (en[n]) begin
        pl_r[n] <= pl_nxt[n];
      end
    end
  end

  // Basis lanes: three Horner steps, the final theta multiply, then the
  // stage weighting.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rkdo_cell u_h1 (
      .clk(clk), .en_a(en[1]), .en_b(en[2]),
      .op_a(COEF[i][3]), .op_b(64'(pl_r[0].theta)), .shamt(SH_THETA),
      .addend(COEF[i][2]), .res(h1[i])
    );
    rkdo_cell u_h2 (
      .clk(clk), .en_a(en[3]), .en_b(en[4]),
      .op_a(h1[i]), .op_b(64'(pl_r[2].theta)), .shamt(SH_THETA),
      .addend(COEF[i][1]), .res(h2[i])
    );
    rkdo_cell u_h3 (
      .clk(clk), .en_a(en[5]), .en_b(en[6]),
      .op_a(h2[i]), .op_b(64'(pl_r[4].theta)), .shamt(SH_THETA),
      .addend(COEF[i][0]), .res(h3[i])
    );
    rkdo_cell u_h4 (
      .clk(clk), .en_a(en[7]), .en_b(en[8]),
      .op_a(h3[i]), .op_b(64'(pl_r[6].theta)), .shamt(SH_THETA),
      .addend((i == 0) ? Q40 : 64'sd0), .res(h4[i])
    );
    rkdo_cell u_term (
      .clk(clk), .en_a(en[9]), .en_b(en[10]),
      .op_a(64'($signed(pl_r[8].k[i]))), .op_b(h4[i]), .shamt(SH_BASIS),
      .addend(64'sd0), .res(term[i])
    );
  end

  // Hold the step size beside the entry stage.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      h_r <= in_step_size;
    end
  end

  // theta * h runs beside the first Horner step.
  rkdo_cell u_thh (
    .clk(clk), .en_a(en[1]), .en_b(en[2]),
    .op_a(64'(pl_r[0].theta)), .op_b(64'(h_r)), .shamt(SH_THETA),
    .addend(64'sd0), .res(thh_res)
  );

  always_comb begin
    sum_nxt = term[0] + term[1] + term[2] + term[3] + term[4];
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      sum_r <= sum_nxt;
    end
  end

  rkdo_cell u_inc (
    .clk(clk), .en_a(en[12]), .en_b(en[13]),
    .op_a(pl_r[11].thh), .op_b(sum_r), .shamt(SH_INC),
    .addend(64'sd0), .res(inc_res)
  );

  // Clamp the increment, add y and saturate to 48 bits.
  always_comb begin
    inc_c = inc_res;
    if (inc_res > INC_LIM) begin
      inc_c = INC_LIM;
    end else if (inc_res < -INC_LIM) begin
      inc_c = -INC_LIM;
    end
    r_full = 64'(pl_r[13].y) + inc_c;
    r_sat  = r_full;
    if (r_full > Y_MAX) begin
      r_sat = Y_MAX;
    end else if (r_full < Y_MIN) begin
      r_sat = Y_MIN;
    end
    y_nxt = r_sat[47:0];
  end

  always_ff @(posedge clk) begin
    if (en[14]) begin
      y_r    <= y_nxt;
      last_r <= pl_r[13].last;
    end
  end

  assign out_valid          = v_r[NUM_STAGES-1];
  assign out_y_interpolated = y_r;
  assign out_last_out       = last_r;

endmodule

@@ hw/rtl/rkdo_checker.sv @@
// ----------------------------------------------------------------------------
// rkdo_checker: port-level checks of the interpolator
// Watches the handshake ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rkdo_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [47:0] out_y_interpolated,
  input logic               out_last_out
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_y_interpolated)
      && $stable(out_last_out))
    else $error("result changed while stalled");

  // Input stalls only behind a waiting result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no blocked result");

  // Reset leaves no result valid.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rk_dense_output_interpolator_top rkdo_checker u_rkdo_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_y_interpolated (out_y_interpolated),
  .out_last_out       (out_last_out)
);
